>>> sv/hrf_pkg.sv
// Shared types, constants and the sat32 saturation helper for the height reference fusion block.
`default_nettype none

package hrf_pkg;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_W      = 10;
  localparam int unsigned REF_W      = 23;
  localparam int unsigned ACC_W      = 16;
  localparam int unsigned SUM_W      = 36;

  localparam logic [11:0] ACC_COEF_Q16 = 12'd1966;
  localparam logic signed [31:0] REF_LIMIT = 32'sd4000000;

  typedef enum logic {
    OP_ACC    = 1'b0,
    OP_FUSION = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_CAPTURE  = 2'd0,
    PH_CAPTURED = 2'd1,
    PH_TAKEOFF  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [2:0]         pad;
    logic               imu_ready;
    logic               auto_takeoff_mode;
    logic               is_flying;
    logic               is_taking_off;
    logic               flow_tof_enabled;
    logic               tof_enabled;
    logic               range_hw_ok;
    logic [15:0]        flow_height_cm;
    logic signed [21:0] baro_height_cm;
    logic signed [15:0] world_acc_z;
  } item_t;

  typedef struct packed {
    logic signed [15:0] acc_filtered;
    logic               fusion_pause;
    logic signed [22:0] ref_height_cm;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic top_ones;
    logic top_zeros;
    top_ones  = &v[SUM_W-1:31];
    top_zeros = ~|v[SUM_W-1:31];
    if (top_ones || top_zeros) begin
      sat32 = v[31:0];
    end else if (v[SUM_W-1]) begin
      sat32 = {1'b1, 31'b0};
    end else begin
      sat32 = {1'b0, {31{1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/hrf_acc_filter.sv
// Q16.16 low-pass filter on vertical acceleration with its state register.
`default_nettype none

module hrf_acc_filter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic signed [15:0]          world_acc_z,
  output logic signed [hrf_pkg::ACC_W-1:0] acc_filtered
);
  import hrf_pkg::*;

  logic signed [31:0] acc_state;
  logic signed [31:0] acc_state_next;
  logic signed [32:0] target;
  logic signed [32:0] diff;
  logic signed [44:0] prod;
  logic signed [44:0] prod_bias;
  logic signed [44:0] prod_biased;
  logic signed [28:0] delta;
  logic signed [32:0] out_biased;

  always_comb begin
    target      = 33'({world_acc_z, 16'b0});
    target      = $signed({world_acc_z[15], world_acc_z, 16'b0});
    diff        = target - 33'(acc_state);
    prod        = 45'(diff) * $signed({33'b0, ACC_COEF_Q16});
    prod_bias   = prod[44] ? 45'sd65535 : 45'sd0;
    prod_biased = prod + prod_bias;
    delta       = 29'(prod_biased >>> 16);
    acc_state_next = acc_state;
    if (step) begin
      acc_state_next = acc_state + 32'(delta);
    end
    out_biased   = 33'(acc_state_next) + (acc_state_next[31] ? 33'sd65535 : 33'sd0);
    acc_filtered = out_biased[31:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_state <= '0;
    end else begin
      acc_state <= acc_state_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/hrf_height_fusion.sv
// Ground offset capture, barometer and range height fusion, and reference selection.
`default_nettype none

module hrf_height_fusion (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire hrf_pkg::item_t              item,
  input  wire logic [hrf_pkg::CFG_W-1:0]   baro_fix_offset,
  output logic signed [hrf_pkg::REF_W-1:0] ref_height_cm,
  output logic                             fusion_pause
);
  import hrf_pkg::*;

  phase_t             phase, phase_next, phase1, phase2;
  logic signed [21:0] ground_baro, ground_baro_next;
  logic signed [11:0] fix_term, fix_term_next;
  logic signed [31:0] baro_rel, baro_rel_next;
  logic signed [31:0] t2b_adjust, t2b_adjust_next, adj1;
  logic signed [31:0] b2t_adjust, b2t_adjust_next;
  logic               latched, latched_next;
  logic [15:0]        held_flow, held_flow_next;
  logic signed [31:0] last_ref, last_ref_next;
  logic               pause, pause_next;

  logic               captured;
  logic               range_on;
  logic               hw_live;
  logic signed [SUM_W-1:0] rel_sum;
  logic signed [SUM_W-1:0] held_ext;
  logic signed [31:0]      range_ref;
  logic signed [SUM_W-1:0] adj_sum;
  logic signed [SUM_W-1:0] adj_bias;
  logic signed [SUM_W-1:0] adj_biased;
  logic signed [SUM_W-1:0] adj_half;

  always_comb begin
    phase_next       = phase;
    ground_baro_next = ground_baro;
    fix_term_next    = fix_term;
    baro_rel_next    = baro_rel;
    t2b_adjust_next  = t2b_adjust;
    b2t_adjust_next  = b2t_adjust;
    latched_next     = latched;
    held_flow_next   = held_flow;
    last_ref_next    = last_ref;
    pause_next       = pause;

    phase1 = phase;
    adj1   = t2b_adjust;
    if (item.is_taking_off) begin
      phase1 = PH_TAKEOFF;
    end else begin
      if (phase == PH_TAKEOFF) begin
        phase1 = PH_CAPTURE;
      end
      adj1 = '0;
    end

    captured = (phase1 != PH_CAPTURE);
    rel_sum  = SUM_W'(item.baro_height_cm) - SUM_W'(ground_baro)
             + SUM_W'(fix_term) + SUM_W'(adj1);
    if (captured) begin
      baro_rel_next = sat32(rel_sum);
      phase2        = phase1;
    end else begin
      ground_baro_next = item.baro_height_cm;
      phase2           = item.imu_ready ? PH_CAPTURED : PH_CAPTURE;
    end

    pause_next    = !item.is_flying && item.auto_takeoff_mode;
    fix_term_next = pause_next ? 12'sd0 : -$signed({1'b0, baro_fix_offset, 1'b0});

    hw_live  = item.range_hw_ok && (phase2 != PH_CAPTURE);
    range_on = hw_live && (item.tof_enabled || item.flow_tof_enabled);

    if (range_on && item.flow_tof_enabled) begin
      held_flow_next = item.flow_height_cm;
    end
    held_ext = $signed(SUM_W'(held_flow_next));
    if (range_on && !latched) begin
      b2t_adjust_next = sat32(SUM_W'(baro_rel_next) - held_ext);
    end
    range_ref  = sat32(held_ext + SUM_W'(b2t_adjust_next));
    adj_sum    = SUM_W'(adj1) + SUM_W'(range_ref) - SUM_W'(baro_rel_next);
    adj_bias   = adj_sum[SUM_W-1] ? SUM_W'(1) : SUM_W'(0);
    adj_biased = adj_sum + adj_bias;
    adj_half   = adj_biased >>> 1;

    if (range_on) begin
      latched_next    = 1'b1;
      last_ref_next   = range_ref;
      t2b_adjust_next = sat32(adj_half);
    end else begin
      if (hw_live) begin
        latched_next = 1'b0;
      end
      last_ref_next   = baro_rel_next;
      t2b_adjust_next = adj1;
    end
    phase_next = phase2;

    if (!step) begin
      phase_next       = phase;
      ground_baro_next = ground_baro;
      fix_term_next    = fix_term;
      baro_rel_next    = baro_rel;
      t2b_adjust_next  = t2b_adjust;
      b2t_adjust_next  = b2t_adjust;
      latched_next     = latched;
      held_flow_next   = held_flow;
      last_ref_next    = last_ref;
      pause_next       = pause;
    end

    if (last_ref_next > REF_LIMIT) begin
      ref_height_cm = REF_W'(REF_LIMIT);
    end else if (last_ref_next < -REF_LIMIT) begin
      ref_height_cm = REF_W'(-REF_LIMIT);
    end else begin
      ref_height_cm = last_ref_next[REF_W-1:0];
    end
    fusion_pause = pause_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_CAPTURE;
      ground_baro <= '0;
      fix_term    <= '0;
      baro_rel    <= '0;
      t2b_adjust  <= '0;
      b2t_adjust  <= '0;
      latched     <= 1'b0;
      held_flow   <= '0;
      last_ref    <= '0;
      pause       <= 1'b0;
    end else begin
      phase       <= phase_next;
      ground_baro <= ground_baro_next;
      fix_term    <= fix_term_next;
      baro_rel    <= baro_rel_next;
      t2b_adjust  <= t2b_adjust_next;
      b2t_adjust  <= b2t_adjust_next;
      latched     <= latched_next;
      held_flow   <= held_flow_next;
      last_ref    <= last_ref_next;
      pause       <= pause_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/height_reference_fusion.sv
// Top level of the height reference fusion block: input register, datapath and result register.
//
// Requests arrive on the s_axis channel; tuser selects an acceleration sample (0) or a
// height fusion step (1), and tdata carries the sensor fields and mode flags.
// Every request produces exactly one result on the m_axis channel with the saturated
// reference height, the estimator pause flag and the filtered vertical acceleration.
// The barometer fix offset is written through cfg_we and cfg_wdata; the user must do so only
// while no request is in flight, as the block itself does not enforce it.
// A request accepted at a clock edge is held in the input register and processed once the result
// register is free; its result is then registered and offered from the result register.
// One request is accepted per cycle while the receiver takes the results; the fusion or
// filter unit selected by the op makes a single state update per request.
// When the receiver stalls, the result register holds its value and the input register
// keeps one further request, after which s_axis_tready drops until the result is taken.
// Reset clears the configuration, the filter state, the fusion state and both valid
// flags, so the block accepts requests as soon as reset is released.
`default_nettype none

module height_reference_fusion (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [hrf_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // world_acc_z, baro_height_cm, flow_height_cm, range_hw_ok, tof_enabled,
  // flow_tof_enabled, is_taking_off, is_flying, auto_takeoff_mode, imu_ready, zero fill.
  input  wire logic [hrf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op.
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // ref_height_cm, fusion_pause, acc_filtered.
  output logic [hrf_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
  import hrf_pkg::*;

  logic [CFG_W-1:0] baro_fix_offset;
  logic             in_valid;
  item_t            in_item;
  op_t              in_op;
  logic             advance;
  logic             acc_step;
  logic             fusion_step;
  result_t          result, result_next;
  logic             out_valid;
  logic signed [ACC_W-1:0] acc_filtered;
  logic signed [REF_W-1:0] ref_height;
  logic                    fusion_pause;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign acc_step      = advance && (in_op == OP_ACC);
  assign fusion_step   = advance && (in_op == OP_FUSION);

  hrf_acc_filter u_acc (
    .clk          (clk),
    .rst          (rst),
    .step         (acc_step),
    .world_acc_z  (in_item.world_acc_z),
    .acc_filtered (acc_filtered)
  );

  hrf_height_fusion u_fusion (
    .clk             (clk),
    .rst             (rst),
    .step            (fusion_step),
    .item            (in_item),
    .baro_fix_offset (baro_fix_offset),
    .ref_height_cm   (ref_height),
    .fusion_pause    (fusion_pause)
  );

  assign result_next = {acc_filtered, fusion_pause, ref_height};

  always_ff @(posedge clk) begin
    if (rst) begin
      baro_fix_offset <= '0;
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        baro_fix_offset <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= item_t'(s_axis_tdata);
      in_op   <= op_t'(s_axis_tuser);
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = result;

endmodule

`default_nettype wire
